// ===== rtl/tht_pkg.sv =====
// Package for the typed handle table: shared types, codes and default sizes.
// Used by tht_ram and typed_handle_table_top; depends on nothing else.

package tht_pkg;

	localparam int CAPACITY_DEF  = 32;
	localparam int TYPE_BITS_DEF = 8;

	// Fixed widths of the stream fields.
	localparam int ACTION_W  = 3;
	localparam int HANDLE_W  = 6;
	localparam int TAG_W     = 8;
	localparam int PAYLOAD_W = 64;
	localparam int STATUS_W  = 2;
	localparam int S_DATA_W  = 80;
	localparam int M_DATA_W  = 72;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC  = 3'd0,
		ACT_LOOKUP = 3'd1,
		ACT_FREE   = 3'd2,
		ACT_SWEEP  = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_INVALID = 2'd1,
		STS_FULL    = 2'd2
	} status_t;

	localparam logic KIND_NOTICE = 1'b0;
	localparam logic KIND_FINAL  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_ACCESS,
		S_SWEEP,
		S_FINAL
	} state_t;

endpackage

// ===== rtl/tht_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// Used by typed_handle_table_top for the entry store and the free-slot stack.

module tht_ram
	import tht_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/typed_handle_table_top.sv =====
// Typed handle table: a fixed-capacity store of typed payloads with a LIFO free list.
// Depends on tht_pkg and tht_ram.

// One request is handled at a time, and s_axis_tready is high only while the table
// is between requests. Allocate and lookup read one memory and then give the result;
// free gives a release notice for a live handle and then its result; free-by-type
// and clear sweep the slots handed out so far, reading the entry memory one slot per
// clock through its single read port, and then give their result. Results
// leave through an output register, so a new request is taken while the last
// result still waits for m_axis_tready; a release notice stalls the sweep until
// the register is free. Handles are slot+1; a handle of zero is never valid.

module typed_handle_table_top
	import tht_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int TYPE_BITS = TYPE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// handle [5:0], type_tag [13:6], payload [77:14], zero [79:78]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// action [2:0]
	input  logic [ACTION_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// status [1:0], handle_out [7:2], payload_out [71:8]
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// kind [0]
	output logic                m_axis_tuser,
	output logic                m_axis_tlast
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ENT_W  = PAYLOAD_W + TYPE_BITS + 1;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     slots_used_q, slots_used_d;
	logic [CNT_W-1:0]     free_depth_q, free_depth_d;
	logic [CNT_W-1:0]     depth_m1;

	// Request held for the duration of its work.
	action_t              act_q;
	logic [HANDLE_W-1:0]  hnd_q;
	logic                 valid_q;
	logic [TYPE_BITS-1:0] tag_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic [SLOT_W-1:0]    idx_q, idx_d;
	status_t              fin_status_q, fin_status_d;
	logic [HANDLE_W-1:0]  fin_handle_q, fin_handle_d;

	// Input unpacking.
	action_t              in_act;
	logic [HANDLE_W-1:0]  in_hnd;
	logic [TYPE_BITS-1:0] in_tag;
	logic [PAYLOAD_W-1:0] in_pay;
	logic                 in_valid;
	logic [SLOT_W-1:0]    in_slot;
	logic                 accept;

	// Memory ports.
	logic                 ent_we, ent_re;
	logic [SLOT_W-1:0]    ent_waddr, ent_raddr;
	logic [ENT_W-1:0]     ent_wdata, ent_rdata;
	logic                 stk_we, stk_re;
	logic [SLOT_W-1:0]    stk_waddr, stk_raddr;
	logic [SLOT_W-1:0]    stk_wdata, stk_rdata;

	logic                 rd_free;
	logic [TYPE_BITS-1:0] rd_type;
	logic [PAYLOAD_W-1:0] rd_pay;
	logic                 live;
	logic                 match;
	logic [CNT_W-1:0]     idx_nxt;
	logic [SLOT_W-1:0]    alloc_slot;

	// Result emission into the output register.
	logic                 can_load;
	logic                 emit;
	logic                 e_kind;
	status_t              e_status;
	logic [HANDLE_W-1:0]  e_handle;
	logic [PAYLOAD_W-1:0] e_payload;
	logic                 e_last;

	logic                 out_valid_q;
	logic                 out_kind_q;
	status_t              out_status_q;
	logic [HANDLE_W-1:0]  out_handle_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic                 out_last_q;

	assign in_act   = action_t'(s_axis_tuser);
	assign in_hnd   = s_axis_tdata[HANDLE_W-1:0];
	assign in_tag   = TYPE_BITS'(s_axis_tdata[HANDLE_W +: TAG_W]);
	assign in_pay   = s_axis_tdata[HANDLE_W+TAG_W +: PAYLOAD_W];
	assign in_valid = (in_hnd != '0) && (in_hnd <= HANDLE_W'(slots_used_q));
	assign in_slot  = SLOT_W'(in_hnd - HANDLE_W'(1));

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign can_load      = !out_valid_q || m_axis_tready;

	assign depth_m1 = free_depth_q - CNT_W'(1);
	assign idx_nxt  = CNT_W'(idx_q) + CNT_W'(1);

	assign rd_pay  = ent_rdata[PAYLOAD_W-1:0];
	assign rd_type = ent_rdata[PAYLOAD_W +: TYPE_BITS];
	assign rd_free = ent_rdata[ENT_W-1];
	assign live    = valid_q && !rd_free;
	assign match   = !rd_free && ((act_q == ACT_CLEAR) || (rd_type == tag_q));

	// A popped stack entry outside the table falls back to slot zero.
	assign alloc_slot = (CNT_W'(stk_rdata) >= CAP_C) ? '0 : stk_rdata;

	tht_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	tht_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (CAPACITY)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slots_used_q <= '0;
			free_depth_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			slots_used_q <= slots_used_d;
			free_depth_q <= free_depth_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= in_act;
			hnd_q   <= in_hnd;
			valid_q <= in_valid;
			tag_q   <= in_tag;
			pay_q   <= in_pay;
		end
		idx_q        <= idx_d;
		fin_status_q <= fin_status_d;
		fin_handle_q <= fin_handle_d;
		if (emit) begin
			out_kind_q    <= e_kind;
			out_status_q  <= e_status;
			out_handle_q  <= e_handle;
			out_payload_q <= e_payload;
			out_last_q    <= e_last;
		end
	end

	always_comb begin
		state_d      = state_q;
		slots_used_d = slots_used_q;
		free_depth_d = free_depth_q;
		idx_d        = idx_q;
		fin_status_d = fin_status_q;
		fin_handle_d = fin_handle_q;
		ent_we       = 1'b0;
		ent_waddr    = idx_q;
		ent_wdata    = {1'b1, rd_type, {PAYLOAD_W{1'b0}}};
		ent_re       = 1'b0;
		ent_raddr    = in_slot;
		stk_we       = 1'b0;
		stk_waddr    = free_depth_q[SLOT_W-1:0];
		stk_wdata    = idx_q;
		stk_re       = 1'b0;
		stk_raddr    = depth_m1[SLOT_W-1:0];
		emit         = 1'b0;
		e_kind       = KIND_FINAL;
		e_status     = STS_OK;
		e_handle     = '0;
		e_payload    = '0;
		e_last       = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_act)
						ACT_ALLOC: begin
							stk_re  = 1'b1;
							state_d = S_ALLOC;
						end
						ACT_LOOKUP, ACT_FREE: begin
							ent_re  = 1'b1;
							state_d = S_ACCESS;
						end
						ACT_SWEEP, ACT_CLEAR: begin
							fin_status_d = STS_OK;
							fin_handle_d = '0;
							if (slots_used_q == '0) begin
								state_d = S_FINAL;
							end else begin
								ent_re    = 1'b1;
								ent_raddr = '0;
								idx_d     = '0;
								state_d   = S_SWEEP;
							end
						end
						default: begin
							fin_status_d = STS_INVALID;
							fin_handle_d = '0;
							state_d      = S_FINAL;
						end
					endcase
				end
			end
			S_ALLOC: begin
				if (can_load) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					ent_wdata = {1'b0, tag_q, pay_q};
					if (free_depth_q != '0) begin
						free_depth_d = depth_m1;
						ent_we       = 1'b1;
						ent_waddr    = alloc_slot;
						e_handle     = HANDLE_W'(alloc_slot) + HANDLE_W'(1);
					end else if (slots_used_q != CAP_C) begin
						slots_used_d = slots_used_q + CNT_W'(1);
						ent_we       = 1'b1;
						ent_waddr    = slots_used_q[SLOT_W-1:0];
						e_handle     = HANDLE_W'(slots_used_q) + HANDLE_W'(1);
					end else begin
						e_status = STS_FULL;
					end
				end
			end
			S_ACCESS: begin
				if (can_load) begin
					emit = 1'b1;
					if (act_q == ACT_LOOKUP) begin
						state_d = S_IDLE;
						if (live && (rd_type == tag_q)) begin
							e_handle  = hnd_q;
							e_payload = rd_pay;
						end else begin
							e_status = STS_INVALID;
						end
					end else if (live) begin
						// Release notice now, final status from S_FINAL.
						e_kind       = KIND_NOTICE;
						e_handle     = hnd_q;
						e_payload    = rd_pay;
						e_last       = 1'b0;
						ent_we       = 1'b1;
						ent_waddr    = SLOT_W'(hnd_q - HANDLE_W'(1));
						stk_wdata    = SLOT_W'(hnd_q - HANDLE_W'(1));
						stk_we       = (free_depth_q < CAP_C);
						free_depth_d = stk_we ? free_depth_q + CNT_W'(1) : free_depth_q;
						fin_status_d = STS_OK;
						fin_handle_d = hnd_q;
						state_d      = S_FINAL;
					end else begin
						e_status = STS_INVALID;
						state_d  = S_IDLE;
					end
				end
			end
			S_SWEEP: begin
				// Read of the next slot overlaps the release of this one, so the sweep
				// stalls only while a notice waits on the output.
				if (!match || can_load) begin
					if (match) begin
						emit         = 1'b1;
						e_kind       = KIND_NOTICE;
						e_handle     = HANDLE_W'(idx_q) + HANDLE_W'(1);
						e_payload    = rd_pay;
						e_last       = 1'b0;
						ent_we       = 1'b1;
						stk_we       = (free_depth_q < CAP_C);
						free_depth_d = stk_we ? free_depth_q + CNT_W'(1) : free_depth_q;
					end
					if (idx_nxt < slots_used_q) begin
						ent_re    = 1'b1;
						ent_raddr = idx_nxt[SLOT_W-1:0];
						idx_d     = idx_nxt[SLOT_W-1:0];
					end else begin
						state_d = S_FINAL;
					end
				end
			end
			S_FINAL: begin
				if (can_load) begin
					emit     = 1'b1;
					e_status = fin_status_q;
					e_handle = fin_handle_q;
					state_d  = S_IDLE;
					if (act_q == ACT_CLEAR) begin
						slots_used_d = '0;
						free_depth_d = '0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_payload_q, out_handle_q, out_status_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_depth_q <= slots_used_q) && (slots_used_q <= CAP_C))
		else $error("free stack deeper than the slots handed out");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || m_axis_tready))
		else $error("result register loaded while still holding a result");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (CNT_W'(idx_q) < slots_used_q))
		else $error("sweep index beyond the slots in use");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
		else $error("last flag does not agree with result kind");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_last) |=> (state_q == S_IDLE))
		else $error("final status sent while the request is still in work");
`endif

endmodule

// ===== tb/tb_typed_handle_table_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for typed_handle_table_top: a ledger class mirrors the table
// and its LIFO free stack, queues the expected results and checks each result.
// Depends on tht_pkg and the typed_handle_table_top RTL.

module tb_typed_handle_table_top
	import tht_pkg::*;
();

	localparam int CAP           = CAPACITY_DEF;
	localparam int HANDLE_MAX    = (1 << HANDLE_W) - 1;
	localparam int IDLE_PCT      = 27;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int TAIL_CYCLES   = 2 * CAP + 16;
	localparam int RANDOM_ITEMS  = 136;
	localparam int RUN_LIMIT_NS  = 2_000_000;

	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;
	localparam logic [TAG_W-1:0]    TAG_MASK = TAG_W'((1 << TYPE_BITS_DEF) - 1);
	localparam logic [TAG_W-1:0]    TAG_POOL [4] = '{8'h00, 8'h3C, 8'hC3, 8'hFF};

	typedef struct {
		logic                 kind;
		status_t              status;
		logic [HANDLE_W-1:0]  handle;
		logic [PAYLOAD_W-1:0] payload;
		logic                 last;
	} table_result_t;

	class handle_ledger;
		logic [PAYLOAD_W-1:0] slot_payload [CAP];
		logic [TAG_W-1:0]     slot_tag [CAP];
		bit                   slot_free [CAP];
		int unsigned          slots_taken;
		int unsigned          reuse_stack [CAP];
		int unsigned          reuse_depth;
		table_result_t        awaited [$];
		int unsigned          errors;

		function new();
			slots_taken = 0;
			reuse_depth = 0;
			errors = 0;
		endfunction

		function void await_result(logic kind, status_t st, logic [HANDLE_W-1:0] hnd,
				logic [PAYLOAD_W-1:0] pay, logic last);
			table_result_t r;
			r.kind = kind;
			r.status = st;
			r.handle = hnd;
			r.payload = pay;
			r.last = last;
			awaited.push_back(r);
		endfunction

		function void release_slot(int unsigned slot);
			await_result(KIND_NOTICE, STS_OK, HANDLE_W'(slot + 1), slot_payload[slot], 1'b0);
			slot_payload[slot] = '0;
			slot_free[slot] = 1'b1;
			if (reuse_depth < CAP) begin
				reuse_stack[reuse_depth] = slot;
				reuse_depth++;
			end
		endfunction

		// Works out every result that one accepted request causes.
		function void note_request(logic [ACTION_W-1:0] act, logic [HANDLE_W-1:0] hnd,
				logic [TAG_W-1:0] tag_in, logic [PAYLOAD_W-1:0] pay);
			bit known;
			int unsigned slot;
			logic [TAG_W-1:0] tag;
			tag = tag_in & TAG_MASK;
			known = hnd >= 1 && hnd <= slots_taken;
			slot = known ? hnd - 1 : 0;
			case (act)
				ACT_ALLOC: begin
					if (reuse_depth > 0) begin
						reuse_depth--;
						slot = reuse_stack[reuse_depth];
					end else if (slots_taken < CAP) begin
						slot = slots_taken;
						slots_taken++;
					end else begin
						await_result(KIND_FINAL, STS_FULL, 0, '0, 1'b1);
						return;
					end
					slot_payload[slot] = pay;
					slot_tag[slot] = tag;
					slot_free[slot] = 1'b0;
					await_result(KIND_FINAL, STS_OK, HANDLE_W'(slot + 1), '0, 1'b1);
				end
				ACT_LOOKUP: begin
					if (known && !slot_free[slot] && slot_tag[slot] == tag)
						await_result(KIND_FINAL, STS_OK, hnd, slot_payload[slot], 1'b1);
					else
						await_result(KIND_FINAL, STS_INVALID, 0, '0, 1'b1);
				end
				ACT_FREE: begin
					if (known && !slot_free[slot]) begin
						release_slot(slot);
						await_result(KIND_FINAL, STS_OK, hnd, '0, 1'b1);
					end else
						await_result(KIND_FINAL, STS_INVALID, 0, '0, 1'b1);
				end
				ACT_SWEEP: begin
					for (int unsigned i = 0; i < slots_taken; i++)
						if (!slot_free[i] && slot_tag[i] == tag)
							release_slot(i);
					await_result(KIND_FINAL, STS_OK, 0, '0, 1'b1);
				end
				ACT_CLEAR: begin
					for (int unsigned i = 0; i < slots_taken; i++)
						if (!slot_free[i])
							release_slot(i);
					slots_taken = 0;
					reuse_depth = 0;
					await_result(KIND_FINAL, STS_OK, 0, '0, 1'b1);
				end
				default: await_result(KIND_FINAL, STS_INVALID, 0, '0, 1'b1);
			endcase
		endfunction

		function void check_result(logic kind, logic [STATUS_W-1:0] st,
				logic [HANDLE_W-1:0] hnd, logic [PAYLOAD_W-1:0] pay, logic last);
			table_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing expected: kind %0d status %0d handle %0d",
					kind, st, hnd);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (hnd !== want.handle) begin
				$error("handle_out: expected %0d, got %0d", want.handle, hnd);
				errors++;
			end
			if (pay !== want.payload) begin
				$error("payload_out: expected %h, got %h", want.payload, pay);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				errors++;
			end
		endfunction

		// Random live handle, or zero when the table holds nothing.
		function int unsigned pick_live();
			int unsigned live [$];
			for (int unsigned i = 0; i < slots_taken; i++)
				if (!slot_free[i])
					live.push_back(i + 1);
			if (live.size() == 0)
				return 0;
			return live[$urandom_range(0, live.size() - 1)];
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [ACTION_W-1:0] s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;

	handle_ledger book = new();
	bit           steady = 1'b0;

	typed_handle_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(0, 99) < 70)
			return TAG_POOL[$urandom_range(0, 3)];
		return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
	endfunction

	function automatic logic [PAYLOAD_W-1:0] pick_payload();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '1;
		if (r < 20)
			return '0;
		return {$urandom(), $urandom()};
	endfunction

	// Valid stays high from one request to the next unless the sender idles.
	task automatic offer(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] hnd,
			input logic [TAG_W-1:0] tag, input logic [PAYLOAD_W-1:0] pay);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_DATA_W'({pay, tag, hnd});
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		book.note_request(act, hnd, tag, pay);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed traffic on live handles; one window leans on allocate
	// so that the table runs full.
	task automatic offer_random(input int unsigned idx);
		int unsigned r;
		int unsigned h;
		int unsigned alloc_pct;
		logic [TAG_W-1:0] tag;
		alloc_pct = (idx >= 60 && idx < 110) ? 80 : 40;
		tag = pick_tag();
		h = book.pick_live();
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			offer(ACT_ALLOC, HANDLE_W'($urandom_range(0, HANDLE_MAX)), tag, pick_payload());
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 30 && h != 0)
			offer(ACT_LOOKUP, HANDLE_W'(h), book.slot_tag[h - 1], pick_payload());
		else if (r < 40)
			offer(ACT_LOOKUP, HANDLE_W'(h), tag, pick_payload());
		else if (r < 65)
			offer(ACT_FREE, HANDLE_W'(h), tag, pick_payload());
		else if (r < 75)
			offer($urandom_range(0, 1) ? ACT_LOOKUP : ACT_FREE,
				HANDLE_W'($urandom_range(0, HANDLE_MAX)), tag, pick_payload());
		else if (r < 88)
			offer(ACT_SWEEP, HANDLE_W'($urandom_range(0, HANDLE_MAX)), tag, pick_payload());
		else if (r < 92)
			offer(ACT_CLEAR, HANDLE_W'($urandom_range(0, HANDLE_MAX)), tag, pick_payload());
		else
			offer(ACTION_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI)),
				HANDLE_W'($urandom_range(0, HANDLE_MAX)), tag, pick_payload());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: no handle is valid and sweeps release nothing.
		offer(ACT_LOOKUP, 0, 8'h00, '0);
		offer(ACT_FREE, 1, 8'h00, '0);
		offer(ACT_SWEEP, 0, 8'h00, '0);
		offer(ACT_CLEAR, 0, 8'h00, '0);
		offer(ACT_UNKNOWN_LO, HANDLE_W'(HANDLE_MAX), 8'hFF, '1);
		offer(ACT_UNKNOWN_LO + ACTION_W'(1), 32, 8'hA5, pick_payload());
		offer(ACT_UNKNOWN_HI, 0, 8'h00, '0);
		offer(ACT_ALLOC, 0, 8'h00, '0);
		offer(ACT_ALLOC, HANDLE_W'(HANDLE_MAX), 8'hFF, '1);
		offer(ACT_ALLOC, 0, 8'h3C, pick_payload());
		offer(ACT_LOOKUP, 1, 8'h00, '1);
		offer(ACT_LOOKUP, 2, 8'hFF, '0);
		offer(ACT_LOOKUP, 2, 8'hFE, '0);
		offer(ACT_LOOKUP, 4, 8'h3C, '0);
		offer(ACT_LOOKUP, 32, 8'h3C, '0);
		offer(ACT_FREE, 2, 8'h00, '0);
		// A second free and a lookup of the freed handle are both refused.
		offer(ACT_FREE, 2, 8'h00, '0);
		offer(ACT_LOOKUP, 2, 8'hFF, '0);
		offer(ACT_ALLOC, 0, 8'hC3, pick_payload());
		offer(ACT_ALLOC, 0, 8'h3C, pick_payload());
		offer(ACT_SWEEP, 0, 8'h3C, '0);
		offer(ACT_ALLOC, 0, 8'h3C, pick_payload());
		offer(ACT_CLEAR, 0, 8'h00, '0);
		offer(ACT_ALLOC, 0, 8'h5A, pick_payload());
		drain();

		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			steady = i >= 104 && i < 134;
			if (i == 100)
				drain();
			offer_random(i);
		end
		steady = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (book.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned results_seen;
		bit held;
		results_seen = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				book.check_result(m_axis_tuser, m_axis_tdata[STATUS_W-1:0],
					m_axis_tdata[STATUS_W +: HANDLE_W],
					m_axis_tdata[STATUS_W + HANDLE_W +: PAYLOAD_W], m_axis_tlast);
				results_seen++;
			end
			if (!held && results_seen >= HOLD_AT) begin
				// Long back-pressure so that the output register and the input stall.
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				m_axis_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
